FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and byte classes for the source text
// tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_MINUS = 3'd3,
    MODE_INT   = 3'd4,
    MODE_DOT   = 3'd5,
    MODE_FRAC  = 3'd6,
    MODE_NAME  = 3'd7
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_STRING = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_NAME   = 2'd2,
    KIND_SYMBOL = 2'd3
  } tok_kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] chr;
    logic       chr_valid;
    logic       start;
    tok_kind_t  kind;
    logic       eot;
    logic       last;
  } tok_res_t;

  // Results caused by one item, in order, plus their count (0..3).
  typedef struct packed {
    tok_res_t [MAX_RES-1:0] res;
    logic [1:0]             cnt;
  } tok_batch_t;

  // Outcome of scanning a byte as if between tokens.
  typedef struct packed {
    logic       emit;
    tok_kind_t  kind;
    scan_mode_t mode;
    logic       set_quote;
    logic       quote_single;
  } fresh_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_COMMA) || (c == CH_DOT) ||
           (c == CH_NL);
  endfunction

  function automatic fresh_t fresh_scan(input logic [7:0] c);
    fresh_t f;
    f = '{emit: 1'b0, kind: KIND_STRING, mode: MODE_IDLE,
          set_quote: 1'b0, quote_single: 1'b0};
    if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      f.emit         = 1'b1;
      f.kind         = KIND_STRING;
      f.mode         = MODE_STR;
      f.set_quote    = 1'b1;
      f.quote_single = (c == CH_SQUOTE);
    end else if (is_digit(c)) begin
      f.emit = 1'b1;
      f.kind = KIND_NUMBER;
      f.mode = MODE_INT;
    end else if (c == CH_MINUS) begin
      f.mode = MODE_MINUS;
    end else if (is_alpha(c) || (c == CH_USCORE)) begin
      f.emit = 1'b1;
      f.kind = KIND_NAME;
      f.mode = MODE_NAME;
    end else if (is_symbol(c)) begin
      f.emit = 1'b1;
      f.kind = KIND_SYMBOL;
    end
    return f;
  endfunction

  function automatic tok_res_t mk_res(input logic [7:0] c, input logic start,
                                      input tok_kind_t kind);
    tok_res_t r;
    r.chr       = c;
    r.chr_valid = 1'b1;
    r.start     = start;
    r.kind      = kind;
    r.eot       = 1'b0;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/stt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_scan
// Input register, scan state and the single-pass decode of one byte into
// its batch of up to three results.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char,
  input  logic               in_last_char,
  input  logic               advance,
  output logic               batch_valid,
  output stt_pkg::tok_batch_t batch
);
  import stt_pkg::*;

  logic       item_valid_r;
  logic [7:0] item_char_r;
  logic       item_last_r;

  scan_mode_t mode_r, mode_nxt;
  logic       quote_single_r, quote_single_nxt;

  tok_res_t [MAX_RES-1:0] res;
  logic [1:0]             cnt;
  fresh_t                 fr;
  logic [7:0]             quote_ch;
  logic                   take_fresh;

  assign in_stall    = item_valid_r && !advance;
  assign batch_valid = item_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_char_r <= in_char;
      item_last_r <= in_last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      quote_single_r <= 1'b0;
    end else if (advance) begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
    end
  end

  always_comb begin
    res              = '0;
    cnt              = 2'd0;
    mode_nxt         = mode_r;
    quote_single_nxt = quote_single_r;
    fr               = fresh_scan(item_char_r);
    quote_ch         = quote_single_r ? CH_SQUOTE : CH_DQUOTE;
    take_fresh       = 1'b0;

    unique case (mode_r)
      MODE_STR: begin
        res[cnt] = mk_res(item_char_r, 1'b0, KIND_STRING);
        cnt      = cnt + 2'd1;
        if (item_char_r == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (item_char_r == quote_ch) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        res[cnt] = mk_res(item_char_r, 1'b0, KIND_STRING);
        cnt      = cnt + 2'd1;
        mode_nxt = MODE_STR;
      end
      MODE_MINUS: begin
        if (is_digit(item_char_r)) begin
          res[cnt] = mk_res(CH_MINUS, 1'b1, KIND_NUMBER);
          cnt      = cnt + 2'd1;
          res[cnt] = mk_res(item_char_r, 1'b0, KIND_NUMBER);
          cnt      = cnt + 2'd1;
          mode_nxt = MODE_INT;
        end else begin
          take_fresh = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(item_char_r)) begin
          res[cnt] = mk_res(item_char_r, 1'b0, KIND_NUMBER);
          cnt      = cnt + 2'd1;
        end else if (item_char_r == CH_DOT) begin
          mode_nxt = MODE_DOT;
        end else begin
          take_fresh = 1'b1;
        end
      end
      MODE_DOT: begin
        if (is_digit(item_char_r)) begin
          res[cnt] = mk_res(CH_DOT, 1'b0, KIND_NUMBER);
          cnt      = cnt + 2'd1;
          res[cnt] = mk_res(item_char_r, 1'b0, KIND_NUMBER);
          cnt      = cnt + 2'd1;
          mode_nxt = MODE_FRAC;
        end else begin
          // dot without a digit stands alone as a symbol
          res[cnt]   = mk_res(CH_DOT, 1'b1, KIND_SYMBOL);
          cnt        = cnt + 2'd1;
          take_fresh = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (is_digit(item_char_r)) begin
          res[cnt] = mk_res(item_char_r, 1'b0, KIND_NUMBER);
          cnt      = cnt + 2'd1;
        end else begin
          take_fresh = 1'b1;
        end
      end
      MODE_NAME: begin
        if (is_name_char(item_char_r)) begin
          res[cnt] = mk_res(item_char_r, 1'b0, KIND_NAME);
          cnt      = cnt + 2'd1;
        end else begin
          take_fresh = 1'b1;
        end
      end
      MODE_IDLE: begin
        take_fresh = 1'b1;
      end
      default: begin
        take_fresh = 1'b1;
      end
    endcase

    if (take_fresh) begin
      mode_nxt = fr.mode;
      if (fr.emit) begin
        res[cnt] = mk_res(item_char_r, 1'b1, fr.kind);
        cnt      = cnt + 2'd1;
      end
      if (fr.set_quote) begin
        quote_single_nxt = fr.quote_single;
      end
    end

    if (item_last_r) begin
      // flush a waiting dot; a waiting minus is dropped
      if (mode_nxt == MODE_DOT) begin
        res[cnt] = mk_res(CH_DOT, 1'b1, KIND_SYMBOL);
        cnt      = cnt + 2'd1;
      end
      res[cnt]           = '0;
      res[cnt].chr       = CH_NUL;
      res[cnt].kind      = KIND_STRING;
      res[cnt].eot       = 1'b1;
      cnt                = cnt + 2'd1;
      mode_nxt           = MODE_IDLE;
      quote_single_nxt   = 1'b0;
    end

    if (cnt != 2'd0) begin
      res[cnt - 2'd1].last = 1'b1;
    end

    batch.res = res;
    batch.cnt = cnt;
  end

endmodule

FILE: rtl/stt_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_outq
// Result register with two pending slots; hands out one result per cycle
// while out_stall is low; takes a new batch once the previous one is drained.
// ----------------------------------------------------------------------------
module stt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               batch_valid,
  input  stt_pkg::tok_batch_t batch,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_char_valid,
  output logic               out_token_start,
  output logic [1:0]         out_token_kind,
  output logic               out_end_of_text,
  output logic               out_last_of_run
);
  import stt_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  tok_res_t out_res_r, out_res_nxt;
  tok_res_t pend0_r, pend0_nxt;
  tok_res_t pend1_r, pend1_nxt;
  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic     out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = batch_valid && (pend_cnt_r == 2'd0) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    pend0_nxt     = pend0_r;
    pend1_nxt     = pend1_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (out_free) begin
      if (pend_cnt_r != 2'd0) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend0_r;
        pend0_nxt     = pend1_r;
        pend_cnt_nxt  = pend_cnt_r - 2'd1;
      end else if (advance && (batch.cnt != 2'd0)) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = batch.res[0];
        pend0_nxt     = batch.res[1];
        pend1_nxt     = batch.res[2];
        pend_cnt_nxt  = batch.cnt - 2'd1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_cnt_r  <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    pend0_r   <= pend0_nxt;
    pend1_r   <= pend1_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_res_r.chr;
  assign out_char_valid  = out_res_r.chr_valid;
  assign out_token_start = out_res_r.start;
  assign out_token_kind  = out_res_r.kind;
  assign out_end_of_text = out_res_r.eot;
  assign out_last_of_run = out_res_r.last;

endmodule

FILE: rtl/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Byte-stream tokenizer: tags kept bytes with token kind and start flag.
// ----------------------------------------------------------------------------
// Takes one source byte per item and returns the bytes that belong to tokens
// (strings, numbers, names, single symbols and newline), one result per
// cycle while out_stall is low. An item that yields zero or one result
// does not hold the input, so plain text streams at one byte per clock while
// unstalled. An item that yields several results (a waiting minus or dot
// released together with the current byte, or the closing result after the
// final byte) holds the input until the single output register has drained
// the batch one result at a time. The first result passes through the input
// register and then the result register on its way to the output.
module source_text_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_token_start,
  output logic [1:0] out_token_kind,
  output logic       out_end_of_text,
  output logic       out_last_of_run
);
  import stt_pkg::*;

  logic       batch_valid;
  tok_batch_t batch;
  logic       advance;

  stt_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .in_last_char(in_last_char),
    .advance     (advance),
    .batch_valid (batch_valid),
    .batch       (batch)
  );

  stt_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .batch_valid    (batch_valid),
    .batch          (batch),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_token_start(out_token_start),
    .out_token_kind (out_token_kind),
    .out_end_of_text(out_end_of_text),
    .out_last_of_run(out_last_of_run)
  );

endmodule

FILE: bench/stt_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_token_checker
// Watches both channels of the source text tokenizer and scores its results.
// ----------------------------------------------------------------------------
// Every accepted byte runs through a behavioral tokenizer that queues the
// results the byte should cause. Every accepted result is compared field by
// field with the oldest queued one. The mismatch count and the number of
// results still owed go back to the testbench top.
module stt_token_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_char_valid,
  input  logic       out_token_start,
  input  logic [1:0] out_token_kind,
  input  logic       out_end_of_text,
  input  logic       out_last_of_run,
  output int         mismatch_count,
  output int         tokens_waiting
);
  import stt_pkg::*;

  scan_mode_t mode_q         = MODE_IDLE;
  logic       quote_single_q = 1'b0;
  tok_res_t   expected_tokens[$];
  tok_res_t   run_q[$];

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return letter(c) || dec_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic single_symbol(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_COMMA) || (c == CH_DOT) || (c == CH_NL);
  endfunction

  task automatic add_tok(input logic [7:0] c, input logic start, input tok_kind_t kind);
    tok_res_t r;
    r.chr       = c;
    r.chr_valid = 1'b1;
    r.start     = start;
    r.kind      = kind;
    r.eot       = 1'b0;
    r.last      = 1'b0;
    run_q = {run_q, r};
  endtask

  // Byte seen between tokens.
  task automatic scan_fresh(input logic [7:0] c);
    mode_q = MODE_IDLE;
    if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      add_tok(c, 1'b1, KIND_STRING);
      quote_single_q = (c == CH_SQUOTE);
      mode_q = MODE_STR;
    end else if (dec_digit(c)) begin
      add_tok(c, 1'b1, KIND_NUMBER);
      mode_q = MODE_INT;
    end else if (c == CH_MINUS) begin
      mode_q = MODE_MINUS;
    end else if (letter(c) || (c == CH_USCORE)) begin
      add_tok(c, 1'b1, KIND_NAME);
      mode_q = MODE_NAME;
    end else if (single_symbol(c)) begin
      add_tok(c, 1'b1, KIND_SYMBOL);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    tok_res_t closing;
    run_q.delete();
    case (mode_q)
      MODE_STR: begin
        add_tok(c, 1'b0, KIND_STRING);
        if (c == CH_BSLASH) begin
          mode_q = MODE_ESC;
        end else if (c == (quote_single_q ? CH_SQUOTE : CH_DQUOTE)) begin
          mode_q = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        add_tok(c, 1'b0, KIND_STRING);
        mode_q = MODE_STR;
      end
      MODE_MINUS: begin
        if (dec_digit(c)) begin
          add_tok(CH_MINUS, 1'b1, KIND_NUMBER);
          add_tok(c, 1'b0, KIND_NUMBER);
          mode_q = MODE_INT;
        end else begin
          scan_fresh(c);
        end
      end
      MODE_INT: begin
        if (dec_digit(c)) begin
          add_tok(c, 1'b0, KIND_NUMBER);
        end else if (c == CH_DOT) begin
          mode_q = MODE_DOT;
        end else begin
          scan_fresh(c);
        end
      end
      MODE_DOT: begin
        if (dec_digit(c)) begin
          add_tok(CH_DOT, 1'b0, KIND_NUMBER);
          add_tok(c, 1'b0, KIND_NUMBER);
          mode_q = MODE_FRAC;
        end else begin
          // no digit after the dot: release it as a symbol
          add_tok(CH_DOT, 1'b1, KIND_SYMBOL);
          scan_fresh(c);
        end
      end
      MODE_FRAC: begin
        if (dec_digit(c)) begin
          add_tok(c, 1'b0, KIND_NUMBER);
        end else begin
          scan_fresh(c);
        end
      end
      MODE_NAME: begin
        if (ident_char(c)) begin
          add_tok(c, 1'b0, KIND_NAME);
        end else begin
          scan_fresh(c);
        end
      end
      default: scan_fresh(c);
    endcase
    if (last) begin
      // flush a waiting dot, drop a waiting minus, then close the text
      if (mode_q == MODE_DOT) begin
        add_tok(CH_DOT, 1'b1, KIND_SYMBOL);
      end
      closing.chr       = CH_NUL;
      closing.chr_valid = 1'b0;
      closing.start     = 1'b0;
      closing.kind      = KIND_STRING;
      closing.eot       = 1'b1;
      closing.last      = 1'b0;
      run_q = {run_q, closing};
      mode_q         = MODE_IDLE;
      quote_single_q = 1'b0;
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last = 1'b1;
    end
    expected_tokens = {expected_tokens, run_q};
  endtask

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    tok_res_t want_tok;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      mode_q         = MODE_IDLE;
      quote_single_q = 1'b0;
      expected_tokens.delete();
      mismatch_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_char, in_last_char);
      end
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("out_char: expected no result, got %0h", out_char);
          errs = errs + 1;
        end else begin
          want_tok = expected_tokens.pop_front();
          errs += field_diff("out_char", want_tok.chr, out_char);
          errs += field_diff("out_char_valid", 8'(want_tok.chr_valid),
                             8'(out_char_valid));
          errs += field_diff("out_token_start", 8'(want_tok.start),
                             8'(out_token_start));
          errs += field_diff("out_token_kind", 8'(want_tok.kind),
                             8'(out_token_kind));
          errs += field_diff("out_end_of_text", 8'(want_tok.eot),
                             8'(out_end_of_text));
          errs += field_diff("out_last_of_run", 8'(want_tok.last),
                             8'(out_last_of_run));
        end
      end
      mismatch_count <= mismatch_count + errs;
    end
    tokens_waiting <= expected_tokens.size();
  end

endmodule

FILE: bench/tb_source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_unit
// Stimulus and verdict for the source text tokenizer.
// ----------------------------------------------------------------------------
// Sends a few hand-picked texts that hit waiting minus and dot, escapes,
// mixed quotes, unterminated strings and end-of-text flushes, then random
// texts built mostly from well-formed tokens with some noise bytes. Sender
// gaps and receiver stalls vary by phase; one stretch holds the output off
// long enough to back up the input. Scoring is done by stt_token_checker.
module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_char      = CH_NUL;
  logic       in_last_char = 1'b0;
  logic       out_stall    = 1'b0;
  logic       rx_hold      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_token_start;
  logic [1:0] out_token_kind;
  logic       out_end_of_text;
  logic       out_last_of_run;

  int mismatch_count;
  int tokens_waiting;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  logic [7:0] text_q[$];
  logic [7:0] symbols[10] = '{CH_EQ, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                              CH_LPAREN, CH_RPAREN, CH_COMMA, CH_DOT, CH_NL};
  logic [7:0] blanks[3]   = '{8'h20, 8'h09, CH_NL};

  always #5 clk = ~clk;

  source_text_tokenizer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char         (in_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_token_start (out_token_start),
    .out_token_kind  (out_token_kind),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

  stt_token_checker token_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char         (in_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_token_start (out_token_start),
    .out_token_kind  (out_token_kind),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run),
    .mismatch_count  (mismatch_count),
    .tokens_waiting  (tokens_waiting)
  );

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_source_text_tokenizer_unit: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char      <= c;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_queued_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Hold new items until every owed result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_waiting != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] name_byte(input logic first);
    case ($urandom_range(first ? 2 : 3))
      0:       return 8'h61 + 8'($urandom_range(25));
      1:       return 8'h41 + 8'($urandom_range(25));
      2:       return CH_USCORE;
      default: return 8'h30 + 8'($urandom_range(9));
    endcase
  endfunction

  task automatic build_text(input int frags);
    int         pick;
    logic [7:0] quote;
    text_q.delete();
    repeat (frags) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        text_q = {text_q, name_byte(1'b1)};
        repeat ($urandom_range(4)) text_q = {text_q, name_byte(1'b0)};
      end else if (pick < 38) begin
        if ($urandom_range(2) == 0) text_q = {text_q, CH_MINUS};
        repeat ($urandom_range(1, 3)) text_q = {text_q, 8'h30 + 8'($urandom_range(9))};
        if ($urandom_range(1) == 1) begin
          text_q = {text_q, CH_DOT};
          repeat ($urandom_range(2)) text_q = {text_q, 8'h30 + 8'($urandom_range(9))};
        end
      end else if (pick < 52) begin
        quote = ($urandom_range(1) == 1) ? CH_SQUOTE : CH_DQUOTE;
        text_q = {text_q, quote};
        repeat ($urandom_range(4)) begin
          case ($urandom_range(9))
            0: begin
              text_q = {text_q, CH_BSLASH};
              text_q = {text_q, ($urandom_range(1) == 1) ? quote : 8'($urandom_range(255))};
            end
            1:       text_q = {text_q, (quote == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE};
            default: text_q = {text_q, 8'($urandom_range(255))};
          endcase
        end
        // leave some strings open to the end of the text
        if ($urandom_range(4) != 0) text_q = {text_q, quote};
      end else if (pick < 68) begin
        text_q = {text_q, symbols[$urandom_range(9)]};
      end else if (pick < 82) begin
        text_q = {text_q, blanks[$urandom_range(2)]};
      end else begin
        text_q = {text_q, 8'($urandom_range(255))};
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hFF, 1'b0);
    send_text("-7.5,2.x-=");
    send_byte(CH_NUL, 1'b0);
    send_text("\"a\\\"'\"");
    send_text("'b");
    send_text("4.");
    send_text("_Z-9");
    send_text("-");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      while (items_sent < 25 + 75 * (phase + 1)) begin
        build_text($urandom_range(1, 8));
        send_queued_text();
      end
      if (phase == 0) begin
        // back up the block: hold the output off while items keep coming
        fork
          begin
            rx_hold <= 1'b1;
            repeat (150) @(posedge clk);
            rx_hold <= 1'b0;
          end
          repeat (3) begin
            build_text(8);
            send_queued_text();
          end
        join
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && tokens_waiting == 0) begin
      $display("tb_source_text_tokenizer_unit: done, clean");
    end else begin
      $display("tb_source_text_tokenizer_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_outq.sv
rtl/source_text_tokenizer_unit.sv
bench/stt_token_checker.sv
bench/tb_source_text_tokenizer_unit.sv
